// File: hw/rtl/triangle_reference_coordinates_macros.svh
// Assertion macros for the triangle reference coordinate block.
// Included by the RTL files that carry assertions.
`ifndef TRIANGLE_REFERENCE_COORDINATES_MACROS_SVH
`define TRIANGLE_REFERENCE_COORDINATES_MACROS_SVH

// Assert an implication on every clock edge outside reset.
`define TRC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Assert an implication whose consequent is checked in the next cycle, outside reset.
`define TRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/trc_pkg.sv
// Types and constants for the triangle reference coordinate block.
// No dependencies.
package trc_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIFF_W  = 33;
  localparam int unsigned PROD_W  = 66;
  localparam int unsigned CROSS_W = 67;
  localparam int unsigned MAG_W   = 66;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_a_x;
    logic signed [COORD_W-1:0] vertex_a_y;
    logic signed [COORD_W-1:0] vertex_b_x;
    logic signed [COORD_W-1:0] vertex_b_y;
    logic signed [COORD_W-1:0] vertex_c_x;
    logic signed [COORD_W-1:0] vertex_c_y;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } trc_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ref_xi;
    logic signed [COORD_W-1:0] ref_eta;
    logic                      degenerate;
    logic                      saturated;
  } trc_out_t;

endpackage

// File: hw/rtl/trc_div.sv
// Pipelined restoring divider: one quotient bit per stage, one beat per cycle while en is high.
// No package dependencies; quotient saturates to QW bits.
module trc_div #(
  parameter int unsigned NW = 82,
  parameter int unsigned DW = 66,
  parameter int unsigned QW = 34,
  parameter int unsigned TW = 4
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag_in,
  output logic [QW-1:0] quo,
  output logic [TW-1:0] tag_out
);
  logic [DW:0]   rem_q [QW+1];
  logic [QW-1:0] num_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic [TW-1:0] tag_q [QW+1];
  logic          ovf_q [QW+1];

  assign rem_q[0] = (DW+1)'(num[NW-1:QW]);
  assign num_q[0] = num[QW-1:0];
  assign den_q[0] = den;
  assign quo_q[0] = '0;
  assign tag_q[0] = tag_in;
  assign ovf_q[0] = ((DW+1)'(num[NW-1:QW]) >= {1'b0, den});

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW+1:0] trial;
    logic [DW:0]   rem_r;
    logic [QW-1:0] num_r;
    logic [DW-1:0] den_r;
    logic [QW-1:0] quo_r;
    logic [TW-1:0] tag_r;
    logic          ovf_r;
    assign trial = {rem_q[s], num_q[s][QW-1]} - {2'b00, den_q[s]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!trial[DW+1]) begin
          rem_r <= trial[DW:0];
          quo_r <= {quo_q[s][QW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_q[s][DW-1:0], num_q[s][QW-1]};
          quo_r <= {quo_q[s][QW-2:0], 1'b0};
        end
        num_r <= {num_q[s][QW-2:0], 1'b0};
        den_r <= den_q[s];
        tag_r <= tag_q[s];
        ovf_r <= ovf_q[s];
      end
    end
    assign rem_q[s+1] = rem_r;
    assign num_q[s+1] = num_r;
    assign den_q[s+1] = den_r;
    assign quo_q[s+1] = quo_r;
    assign tag_q[s+1] = tag_r;
    assign ovf_q[s+1] = ovf_r;
  end

  assign quo     = ovf_q[QW] ? '1 : quo_q[QW];
  assign tag_out = tag_q[QW];
endmodule

// File: hw/rtl/triangle_reference_coordinates.sv
// Triangle reference coordinates: maps a point into (xi, eta) of a triangle, all signed
// fixed point, with one beat in and one beat out per cycle unless stalled. From input
// accept to out_valid there is one stage each for edges, products, cross terms and
// magnitudes, 34 divider stages (one quotient bit each), then one output stage; the
// depth does not vary with FRAC_BITS. The whole pipe advances only when the output
// register is free or being taken, so a stall holds every stage and in_ready follows
// out_ready while a result waits. Depends on trc_pkg, trc_div and the macros header.
`include "triangle_reference_coordinates_macros.svh"
module triangle_reference_coordinates #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  trc_pkg::trc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output trc_pkg::trc_out_t out_data
);
  import trc_pkg::*;

  localparam int unsigned QW    = 34;
  localparam int unsigned NW    = MAG_W + FRAC_BITS;
  localparam int unsigned DEPTH = 4 + QW;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic [DEPTH-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[DEPTH-2:0], in_valid};
  end

  // stage 1: edges
  logic signed [DIFF_W-1:0] bax, bay, cax, cay, pax, pay;
  always_ff @(posedge clk) begin
    if (en) begin
      bax <= DIFF_W'(in_data.vertex_b_x) - DIFF_W'(in_data.vertex_a_x);
      bay <= DIFF_W'(in_data.vertex_b_y) - DIFF_W'(in_data.vertex_a_y);
      cax <= DIFF_W'(in_data.vertex_c_x) - DIFF_W'(in_data.vertex_a_x);
      cay <= DIFF_W'(in_data.vertex_c_y) - DIFF_W'(in_data.vertex_a_y);
      pax <= DIFF_W'(in_data.point_x) - DIFF_W'(in_data.vertex_a_x);
      pay <= DIFF_W'(in_data.point_y) - DIFF_W'(in_data.vertex_a_y);
    end
  end

  // stage 2: six products
  logic signed [PROD_W-1:0] p_d0, p_d1, p_x0, p_x1, p_e0, p_e1;
  always_ff @(posedge clk) begin
    if (en) begin
      p_d0 <= PROD_W'(bax) * PROD_W'(cay);
      p_d1 <= PROD_W'(bay) * PROD_W'(cax);
      p_x0 <= PROD_W'(cay) * PROD_W'(pax);
      p_x1 <= PROD_W'(cax) * PROD_W'(pay);
      p_e0 <= PROD_W'(bax) * PROD_W'(pay);
      p_e1 <= PROD_W'(bay) * PROD_W'(pax);
    end
  end

  // stage 3: cross terms
  logic signed [CROSS_W-1:0] delta, nxi, neta;
  always_ff @(posedge clk) begin
    if (en) begin
      delta <= CROSS_W'(p_d0) - CROSS_W'(p_d1);
      nxi   <= CROSS_W'(p_x0) - CROSS_W'(p_x1);
      neta  <= CROSS_W'(p_e0) - CROSS_W'(p_e1);
    end
  end

  // stage 4: magnitudes and signs
  logic [MAG_W-1:0] mag_d, mag_x, mag_e;
  logic             neg_x, neg_e, degen;
  always_ff @(posedge clk) begin
    if (en) begin
      mag_d <= MAG_W'(delta[CROSS_W-1] ? -delta : delta);
      mag_x <= MAG_W'(nxi[CROSS_W-1] ? -nxi : nxi);
      mag_e <= MAG_W'(neta[CROSS_W-1] ? -neta : neta);
      neg_x <= nxi[CROSS_W-1] ^ delta[CROSS_W-1];
      neg_e <= neta[CROSS_W-1] ^ delta[CROSS_W-1];
      degen <= (delta == '0);
    end
  end

  logic [QW-1:0] q_x, q_e;
  logic [1:0]    t_x;
  logic [0:0]    t_e;

  trc_div #(.NW(NW), .DW(MAG_W), .QW(QW), .TW(2)) u_div_xi (
    .clk, .en,
    .num({mag_x, FRAC_BITS'(0)}), .den(mag_d),
    .tag_in({neg_x, degen}), .quo(q_x), .tag_out(t_x)
  );
  trc_div #(.NW(NW), .DW(MAG_W), .QW(QW), .TW(1)) u_div_eta (
    .clk, .en,
    .num({mag_e, FRAC_BITS'(0)}), .den(mag_d),
    .tag_in(neg_e), .quo(q_e), .tag_out(t_e)
  );

  function automatic logic [32:0] sat_coord(input logic [QW-1:0] q, input logic neg);
    logic [32:0] r;
    if (neg) begin
      if (q > QW'(34'h080000000)) r = {1'b1, 32'h80000000};
      else r = {1'b0, 32'(-q)};
    end else begin
      if (q > QW'(34'h07FFFFFFF)) r = {1'b1, 32'h7FFFFFFF};
      else r = {1'b0, q[31:0]};
    end
    return r;
  endfunction

  logic [32:0] r_x, r_e;
  assign r_x = sat_coord(q_x, t_x[1]);
  assign r_e = sat_coord(q_e, t_e[0]);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vld[DEPTH-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (t_x[0]) begin
        out_data <= '{ref_xi: '0, ref_eta: '0, degenerate: 1'b1, saturated: 1'b0};
      end else begin
        out_data.ref_xi     <= r_x[31:0];
        out_data.ref_eta    <= r_e[31:0];
        out_data.degenerate <= 1'b0;
        out_data.saturated  <= r_x[32] | r_e[32];
      end
    end
  end

  `TRC_ASSERT_IMP(a_degen_zero, clk, rst, out_valid && out_data.degenerate,
    out_data.ref_xi == 0 && out_data.ref_eta == 0 && !out_data.saturated)
  `TRC_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))
  `TRC_ASSERT_IMP(a_ready, clk, rst, !out_valid, in_ready)
endmodule
